// File: sv/afrc_pkg.sv
// ----------------------------------------------------------------------------
// afrc_pkg: shared types and constants for the API frame receive checker
// Result kinds, the command word passed from front to back, frame constants.
// ----------------------------------------------------------------------------
package afrc_pkg;

  // Default and upper bound of the frame buffer size
  localparam int FRAME_BUF_DEF = 64;
  localparam int FRAME_BUF_MAX = 64;

  // Frame layout
  localparam int DATA_FIRST   = 15;    // first buffered payload position
  localparam int HDR_LEN      = 3;     // start byte plus two length bytes
  localparam int DELIVERY_LEN = 7;     // length of a delivery report frame
  localparam logic [7:0] CSUM_BASE = 8'hFF;

  // Payload count width, sized for the largest frame buffer
  localparam int CNT_W = $clog2(FRAME_BUF_MAX - DATA_FIRST + 1);

  // Command queue depth between front and back
  localparam int CMD_Q_DEPTH = 2;

  typedef enum logic [2:0] {
    KIND_PAYLOAD     = 3'd0,
    KIND_DATA_OK     = 3'd1,
    KIND_DELIVERY_OK = 3'd2,
    KIND_OTHER_OK    = 3'd3,
    KIND_CSUM_ERR    = 3'd4,
    KIND_TOO_LONG    = 3'd5
  } kind_t;

  // One command: a status kind, preceded by count payload words from the store
  typedef struct packed {
    kind_t             kind;
    logic [CNT_W-1:0]  count;
  } cmd_t;

endpackage

// File: sv/afrc_if.sv
// ----------------------------------------------------------------------------
// afrc_if: valid/ready channels of the API frame receive checker
// Input byte channel and result channel.
// ----------------------------------------------------------------------------
interface afrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface afrc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, output kind, output payload_byte, output last,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte, input last,
                  output ready);
endinterface

// File: sv/afrc_ram.sv
// ----------------------------------------------------------------------------
// afrc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module afrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 49,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// File: sv/afrc_front.sv
// ----------------------------------------------------------------------------
// afrc_front: frame parser front end
// Tracks position, length and checksum, stores payload, issues commands.
// ----------------------------------------------------------------------------
module afrc_front #(
  parameter int  FRAME_BUF = afrc_pkg::FRAME_BUF_DEF,
  localparam int DEPTH     = FRAME_BUF - afrc_pkg::DATA_FIRST,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  afrc_in_if.sink           in_ch,
  input  logic              q_full,
  input  logic              drain_done,
  output logic              push,
  output afrc_pkg::cmd_t    push_cmd,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [7:0]        ram_wdata
);

  localparam int CW = afrc_pkg::CNT_W;
  localparam logic [16:0] END_MAX = 17'(FRAME_BUF);
  localparam logic [16:0] HDR     = 17'(afrc_pkg::HDR_LEN);

  logic [6:0]    pos_r, pos_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [1:0]    zeros_r, zeros_nxt;
  logic          idle_r, idle_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          drain_r, drain_nxt;

  logic          accept;
  logic [6:0]    pos_inc;
  logic [16:0]   end_pos;
  logic [15:0]   full_len;

  // Hold off bytes that could overwrite the store while it is still draining
  assign in_ch.ready = !q_full &&
                       !(drain_r && !idle_r && (pos_r >= 7'(afrc_pkg::DATA_FIRST - 1)));
  assign accept      = in_ch.valid && in_ch.ready;

  assign pos_inc   = pos_r + 7'd1;
  assign end_pos   = {1'b0, len_r} + HDR;
  assign full_len  = {len_r[15:8], in_ch.rx_byte};
  assign ram_waddr = cnt_r[AW-1:0];
  assign ram_wdata = in_ch.rx_byte;

  always_comb begin
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    zeros_nxt = zeros_r;
    idle_nxt  = idle_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    push_cmd  = '{kind: afrc_pkg::KIND_DATA_OK, count: '0};
    ram_we    = 1'b0;

    if (accept) begin
      if (in_ch.frame_start) begin
        pos_nxt   = '0;
        len_nxt   = '0;
        sum_nxt   = '0;
        zeros_nxt = '0;
        cnt_nxt   = '0;
        idle_nxt  = 1'b0;
      end else if (!idle_r) begin
        pos_nxt = pos_inc;
        priority if (pos_inc == 7'd1) begin
          len_nxt = {in_ch.rx_byte, 8'h00};
        end else if (pos_inc == 7'd2) begin
          len_nxt = full_len;
          if (({1'b0, full_len} + HDR) > END_MAX) begin
            idle_nxt      = 1'b1;
            push          = 1'b1;
            push_cmd.kind = afrc_pkg::KIND_TOO_LONG;
          end
        end else if ({10'd0, pos_inc} < end_pos) begin
          sum_nxt = sum_r + in_ch.rx_byte;
          if (in_ch.rx_byte == 8'h00) begin
            zeros_nxt = (zeros_r == 2'd3) ? 2'd3 : zeros_r + 2'd1;
          end else begin
            zeros_nxt = '0;
          end
          if ((pos_inc >= 7'(afrc_pkg::DATA_FIRST)) && (cnt_r < CW'(DEPTH))) begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
        end else begin
          // checksum byte closes the frame
          idle_nxt = 1'b1;
          push     = 1'b1;
          if ((afrc_pkg::CSUM_BASE - sum_r) != in_ch.rx_byte) begin
            push_cmd.kind = afrc_pkg::KIND_CSUM_ERR;
          end else if (len_r == 16'(afrc_pkg::DELIVERY_LEN)) begin
            push_cmd.kind = (zeros_r == 2'd3) ? afrc_pkg::KIND_DELIVERY_OK
                                              : afrc_pkg::KIND_OTHER_OK;
          end else begin
            push_cmd.kind  = afrc_pkg::KIND_DATA_OK;
            push_cmd.count = cnt_r;
          end
        end
      end
    end

    drain_nxt = drain_r;
    if (drain_done) begin
      drain_nxt = 1'b0;
    end
    if (push && (push_cmd.count != '0)) begin
      drain_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      len_r   <= '0;
      sum_r   <= '0;
      zeros_r <= '0;
      idle_r  <= 1'b1;
      cnt_r   <= '0;
      drain_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      zeros_r <= zeros_nxt;
      idle_r  <= idle_nxt;
      cnt_r   <= cnt_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

// File: sv/afrc_cmd_q.sv
// ----------------------------------------------------------------------------
// afrc_cmd_q: short command queue between front and back
// Register-based FIFO of command words.
// ----------------------------------------------------------------------------
module afrc_cmd_q (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  afrc_pkg::cmd_t   push_cmd,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output afrc_pkg::cmd_t   head
);

  localparam int QD = afrc_pkg::CMD_Q_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;

  afrc_pkg::cmd_t entry_r [QD];
  logic [PW-1:0]  wptr_r, rptr_r;
  logic [PW:0]    fill_r;

  assign full  = (fill_r == (PW + 1)'(QD));
  assign empty = (fill_r == '0);
  assign head  = entry_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_cmd;
    end
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(QD - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(QD - 1)) ? '0 : rptr_r + PW'(1);
      end
      fill_r <= fill_r + (PW + 1)'(push) - (PW + 1)'(pop);
    end
  end

endmodule

// File: sv/afrc_back.sv
// ----------------------------------------------------------------------------
// afrc_back: result sequencer
// Pops commands, drains stored payload words, emits the closing status word.
// ----------------------------------------------------------------------------
module afrc_back #(
  parameter int  FRAME_BUF = afrc_pkg::FRAME_BUF_DEF,
  localparam int DEPTH     = FRAME_BUF - afrc_pkg::DATA_FIRST,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  afrc_pkg::cmd_t    q_head,
  output logic              q_pop,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  logic [7:0]        ram_rdata,
  output logic              drain_done,
  afrc_out_if.source        out_ch
);

  localparam int CW = afrc_pkg::CNT_W;

  typedef enum logic [1:0] {ST_IDLE, ST_DATA, ST_STAT} state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  total_r, total_nxt;
  logic [CW-1:0]  idx_inc;
  logic           out_free;
  logic           valid_r, valid_nxt;
  logic [2:0]     kind_r, kind_nxt;
  logic [7:0]     byte_r, byte_nxt;
  logic           last_r, last_nxt;

  assign out_free       = !valid_r || out_ch.ready;
  assign idx_inc        = idx_r + CW'(1);
  assign out_ch.valid        = valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.payload_byte = byte_r;
  assign out_ch.last         = last_r;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    total_nxt  = total_r;
    valid_nxt  = valid_r && !out_ch.ready;
    kind_nxt   = kind_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    q_pop      = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = idx_r[AW-1:0];
    drain_done = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (q_head.count == '0) begin
            valid_nxt = 1'b1;
            kind_nxt  = q_head.kind;
            byte_nxt  = '0;
            last_nxt  = 1'b1;
          end else begin
            total_nxt = q_head.count;
            idx_nxt   = '0;
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_nxt = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (out_free) begin
          valid_nxt = 1'b1;
          kind_nxt  = afrc_pkg::KIND_PAYLOAD;
          byte_nxt  = ram_rdata;
          last_nxt  = 1'b0;
          if (idx_inc == total_r) begin
            drain_done = 1'b1;
            state_nxt  = ST_STAT;
          end else begin
            idx_nxt   = idx_inc;
            ram_re    = 1'b1;
            ram_raddr = idx_inc[AW-1:0];
          end
        end
      end
      ST_STAT: begin
        if (out_free) begin
          valid_nxt = 1'b1;
          kind_nxt  = afrc_pkg::KIND_DATA_OK;
          byte_nxt  = '0;
          last_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    total_r <= total_nxt;
    kind_r  <= kind_nxt;
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

// File: sv/api_frame_receive_checker.sv
// ----------------------------------------------------------------------------
// api_frame_receive_checker: radio API frame parser with checksum check
// Result path: a status-only result is queued, then registered at the output
//   after the closing byte is taken; stored payload words also pass the store's
//   read register, one per cycle unless the output stalls, then the status word.
// Throughput: one byte per cycle; input stalls while a frame reaches its
//   payload area before the previous frame's drain has finished, or when
//   the two-entry command queue is full.
// Reset: synchronous, active low; the parser waits for a frame start.
// ----------------------------------------------------------------------------
module api_frame_receive_checker #(
  parameter int FRAME_BUF = afrc_pkg::FRAME_BUF_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  afrc_in_if.sink     in_ch,
  afrc_out_if.source  out_ch
);

  // Payload store depth: positions from the first data byte up to the buffer end
  localparam int DEPTH = FRAME_BUF - afrc_pkg::DATA_FIRST;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Front to queue
  logic            push;
  afrc_pkg::cmd_t  push_cmd;
  // Queue to back
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  afrc_pkg::cmd_t  q_head;
  // Payload store ports
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;
  // Back tells front the store is free again
  logic            drain_done;

  // Front: parse bytes, sum the checksum, write payload, push at most one command per frame
  afrc_front #(
    .FRAME_BUF (FRAME_BUF)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .drain_done (drain_done),
    .push       (push),
    .push_cmd   (push_cmd),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  // Decouple the parser from the result side
  afrc_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Payload store; entries are only read after the current frame wrote them
  afrc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Back: drain payload words, then close the run with a status word
  afrc_back #(
    .FRAME_BUF (FRAME_BUF)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .drain_done (drain_done),
    .out_ch     (out_ch)
  );

endmodule

// File: verif/afrc_tb_pkg.sv
// ----------------------------------------------------------------------------
// afrc_tb_pkg: expected-result tracking for the API frame receive checker
// Follows the frame parser byte by byte and queues the words it must emit.
// ----------------------------------------------------------------------------
package afrc_tb_pkg;
  import afrc_pkg::*;

  localparam int FRAME_BUF   = FRAME_BUF_DEF;
  localparam int STORE_DEPTH = FRAME_BUF - DATA_FIRST;

  typedef struct {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

  class frame_result_board;
    int unsigned errors;
    result_t     expected_q[$];

    logic [6:0]  pos;
    logic [15:0] frame_len;
    logic [7:0]  byte_sum;
    logic [1:0]  zero_run;
    logic        waiting;
    int unsigned stored;
    logic [7:0]  payload[STORE_DEPTH];

    function new();
      errors    = 0;
      pos       = '0;
      frame_len = '0;
      byte_sum  = '0;
      zero_run  = '0;
      waiting   = 1'b1;
      stored    = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void push(kind_t k, logic [7:0] b, logic l);
      result_t r;
      r.kind         = k;
      r.payload_byte = b;
      r.last         = l;
      expected_q.push_back(r);
    endfunction

    // Advance the parser by one word; return 1 if the word was not ignored.
    function bit take_byte(logic [7:0] b, logic start);
      int unsigned p;
      int unsigned close_pos;
      logic [7:0]  want_csum;
      if (start) begin
        pos       = '0;
        frame_len = '0;
        byte_sum  = '0;
        zero_run  = '0;
        stored    = 0;
        waiting   = 1'b0;
        return 1'b1;
      end
      if (waiting)
        return 1'b0;

      p         = pos + 1;
      pos       = p[6:0];
      close_pos = frame_len + HDR_LEN;

      if (p == 1) begin
        frame_len = {b, 8'h00};
        return 1'b1;
      end
      if (p == 2) begin
        frame_len[7:0] = b;
        if (frame_len + HDR_LEN > FRAME_BUF) begin
          waiting = 1'b1;
          push(KIND_TOO_LONG, 8'h00, 1'b1);
        end
        return 1'b1;
      end
      if (p < close_pos) begin
        byte_sum = byte_sum + b;
        // zero run saturates at three
        if (b == 8'h00)
          zero_run = (zero_run == 2'd3) ? 2'd3 : zero_run + 2'd1;
        else
          zero_run = 2'd0;
        if (p >= DATA_FIRST && stored < STORE_DEPTH) begin
          payload[stored] = b;
          stored++;
        end
        return 1'b1;
      end

      // checksum word closes the frame
      waiting   = 1'b1;
      want_csum = CSUM_BASE - byte_sum;
      if (want_csum != b)
        push(KIND_CSUM_ERR, 8'h00, 1'b1);
      else if (frame_len == DELIVERY_LEN)
        push((zero_run == 2'd3) ? KIND_DELIVERY_OK : KIND_OTHER_OK, 8'h00, 1'b1);
      else begin
        for (int i = 0; i < stored; i++)
          push(KIND_PAYLOAD, payload[i], 1'b0);
        push(KIND_DATA_OK, 8'h00, 1'b1);
      end
      return 1'b1;
    endfunction

    task match_result(logic [2:0] kind, logic [7:0] b, logic l);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word kind %0d byte %02h last %0b", kind, b, l));
        return;
      end
      want = expected_q.pop_front();
      if (kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", kind, want.kind));
      if (b !== want.payload_byte)
        report($sformatf("payload_byte %02h, expected %02h", b, want.payload_byte));
      if (l !== want.last)
        report($sformatf("last %0b, expected %0b", l, want.last));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench for api_frame_receive_checker
// Feeds directed and random radio API frames with random gaps on both sides
// and checks every result word against a byte-level frame parser.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import afrc_pkg::*;
  import afrc_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  // calm stretches: no gaps on either side
  bit                calm;
  int unsigned       taken_cnt;
  frame_result_board board;

  afrc_in_if  in_ch();
  afrc_out_if out_ch();

  api_frame_receive_checker u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 30);
  endfunction

  // Present one word and hold it until the block takes it. Valid stays high
  // on return so that back-to-back words need no extra edge.
  task automatic send_word(logic [7:0] b, logic s);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.rx_byte     <= b;
    in_ch.frame_start <= s;
    do @(posedge clk); while (!in_ch.ready);
    void'(board.take_byte(b, s));
    taken_cnt++;
  endtask

  // One random frame: mostly well formed, with oversize lengths, bad
  // checksums, frames cut short by the next start, and idle noise after.
  task automatic send_frame();
    int          flavor;
    int          cut;
    bit          tail_zero;
    logic [15:0] len;
    logic [7:0]  sum;
    logic [7:0]  b;
    calm   = ($urandom_range(0, 4) == 0);
    flavor = $urandom_range(0, 99);
    if (flavor < 8) begin
      // oversize: sit right on the boundary half the time
      if ($urandom_range(0, 1) != 0)
        len = 16'(FRAME_BUF - HDR_LEN + 1);
      else
        len = 16'($urandom_range(FRAME_BUF - HDR_LEN + 2, 16'hFFFF));
    end else if (flavor < 30)
      len = 16'(DELIVERY_LEN);
    else if (flavor < 58)
      len = 16'($urandom_range(0, 12));
    else if (flavor < 88)
      len = 16'($urandom_range(13, 30));
    else if ($urandom_range(0, 2) == 0)
      len = 16'(FRAME_BUF - HDR_LEN);
    else
      len = 16'($urandom_range(31, FRAME_BUF - HDR_LEN));

    tail_zero = ($urandom_range(0, 9) < 6);
    send_word(8'($urandom), 1'b1);
    send_word(len[15:8], 1'b0);
    send_word(len[7:0], 1'b0);

    if (len + HDR_LEN > FRAME_BUF) begin
      // drop the rest of the frame; the parser ignores it
      repeat ($urandom_range(0, 4)) send_word(8'($urandom), 1'b0);
      return;
    end

    cut = ($urandom_range(0, 99) < 8) ? $urandom_range(0, len) : -1;
    sum = 8'h00;
    for (int i = 0; i <= len; i++) begin
      // a cut frame is abandoned and restarted by the next frame start
      if (i == cut)
        return;
      if (i < len) begin
        if (len == DELIVERY_LEN && tail_zero && i >= DELIVERY_LEN - 3)
          b = 8'h00;
        else if ($urandom_range(0, 3) == 0)
          b = 8'h00;
        else
          b = 8'($urandom);
        sum = sum + b;
      end else begin
        b = CSUM_BASE - sum;
        if ($urandom_range(0, 99) < 15)
          b = b ^ 8'($urandom_range(1, 255));
      end
      send_word(b, 1'b0);
    end

    // idle noise between frames
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0);
  endtask

  // Result side: random stalls, none during calm stretches.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = calm ? 0 : pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Check every accepted result word against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.match_result(out_ch.kind, out_ch.payload_byte, out_ch.last);
  end

  initial begin
    logic [7:0] report_body[DELIVERY_LEN];
    logic [7:0] sum;
    board     = new();
    taken_cnt = 0;
    in_ch.valid       <= 1'b0;
    in_ch.rx_byte     <= 8'h00;
    in_ch.frame_start <= 1'b0;
    rst_n             <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Bytes while idle: no frame start yet, so these are ignored.
    send_word(8'hA5, 1'b0);
    send_word(8'h00, 1'b0);

    // Oversize length: all-ones length gives too_long at the second length byte.
    send_word(8'hFF, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);

    // Start while busy: abandon a partial frame, then a delivery report
    // whose last three body bytes are zero.
    send_word(8'h7E, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h7E, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'(DELIVERY_LEN), 1'b0);
    report_body = '{8'h8B, 8'h01, 8'h23, 8'h45, 8'h00, 8'h00, 8'h00};
    sum = 8'h00;
    foreach (report_body[i]) begin
      sum = sum + report_body[i];
      send_word(report_body[i], 1'b0);
    end
    send_word(CSUM_BASE - sum, 1'b0);

    // Empty frame: zero length, checksum of an empty sum.
    send_word(8'h00, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(CSUM_BASE, 1'b0);

    while (taken_cnt < 265)
      send_frame();

    // Drain: wait for every expected word, then watch for strays.
    in_ch.valid <= 1'b0;
    calm = 1'b0;
    while (board.pending() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (board.errors == 0)
      $display("api_frame_receive_checker regression: pass");
    else
      $display("api_frame_receive_checker regression: fail");
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin
    #5000000;
    $display("api_frame_receive_checker regression: fail");
    $finish;
  end

endmodule
